@@ src/b64e_pkg.sv @@
`timescale 1ns / 1ps

package b64e_pkg;

    // Group phase codes: position of the next byte within its three-byte group.
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    // ASCII pad character.
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Most characters that one byte can produce.
    localparam int unsigned MAX_CHARS = 4;

    // One byte's worth of output characters, as handed from front to back.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;     // ASCII characters, slot 0 first
        logic [2:0]                num_chars; // number of valid slots, 1 to 4
        logic                      msg_end;   // the last slot ends the message
    } job_t;

    // Maps a 6-bit index to its character in the standard alphabet.
    function automatic logic [7:0] sextet_char(input logic [5:0] idx);
        logic [7:0] v;
        begin
            v = {2'b00, idx};
            if (idx < 6'd26) begin
                sextet_char = 8'h41 + v;
            end else if (idx < 6'd52) begin
                sextet_char = 8'h61 + v - 8'd26;
            end else if (idx < 6'd62) begin
                sextet_char = 8'h30 + v - 8'd52;
            end else if (idx == 6'd62) begin
                sextet_char = 8'h2B;
            end else begin
                sextet_char = 8'h2F;
            end
        end
    endfunction

endpackage

@@ src/base64_stream_encoder.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Ports                                   Carries
// s_        in         s_valid, s_ready, s_data_byte, s_final_byte   one raw byte
// m_        out        m_valid, m_ready, m_out_char, m_end_of_text   one Base64 char
//
// Each byte is one input transfer; its one to four characters leave one per cycle
// while m_ready is high, so the output port sets the rate in a long message.
// A byte's first character is registered in a queue slot, then in the output
// register, before it can be taken.
// Reset (aresetn, synchronous) clears the group phase, queue and output valid.
// The front stalls only when the job queue is full; the back stalls only on m_ready.
module base64_stream_encoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_final_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_end_of_text
);
    import b64e_pkg::*;

    logic push;
    logic pop;
    logic queue_full;
    logic head_valid;
    job_t push_job;
    job_t head_job;

    // Front: accept bytes and turn them into character jobs.
    b64e_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .queue_full   (queue_full),
        .push         (push),
        .push_job     (push_job)
    );

    // Job queue between front and back.
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Back: emit characters one at a time.
    b64e_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_end_of_text (m_end_of_text)
    );

endmodule

@@ src/b64e_front.sv @@
`timescale 1ns / 1ps

module b64e_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_data_byte,
    input  logic          s_final_byte,
    input  logic          queue_full,
    output logic          push,
    output b64e_pkg::job_t push_job
);
    import b64e_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic [5:0] carry_reg, carry_next;
    logic [5:0] new_carry;

    // A request is taken whenever the queue has a free slot.
    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    // Classify the byte by its group phase and build its characters.
    always_comb begin
        push_job         = '0;
        push_job.msg_end = s_final_byte;
        new_carry        = '0;
        phase_next       = phase_reg;
        carry_next       = carry_reg;
        unique case (phase_reg)
            PHASE_SECOND: begin
                new_carry             = {s_data_byte[3:0], 2'b00};
                push_job.chars[0]     = sextet_char(carry_reg | {2'b00, s_data_byte[7:4]});
                push_job.num_chars    = 3'd1;
                if (s_final_byte) begin
                    push_job.chars[1]  = sextet_char(new_carry);
                    push_job.chars[2]  = PAD_CHAR;
                    push_job.num_chars = 3'd3;
                end
                phase_next = PHASE_THIRD;
                carry_next = new_carry;
            end
            PHASE_THIRD: begin
                push_job.chars[0]  = sextet_char(carry_reg | {4'b0000, s_data_byte[7:6]});
                push_job.chars[1]  = sextet_char(s_data_byte[5:0]);
                push_job.num_chars = 3'd2;
                phase_next         = PHASE_FIRST;
                carry_next         = '0;
            end
            default: begin
                new_carry          = {s_data_byte[1:0], 4'b0000};
                push_job.chars[0]  = sextet_char(s_data_byte[7:2]);
                push_job.num_chars = 3'd1;
                if (s_final_byte) begin
                    push_job.chars[1]  = sextet_char(new_carry);
                    push_job.chars[2]  = PAD_CHAR;
                    push_job.chars[3]  = PAD_CHAR;
                    push_job.num_chars = 3'd4;
                end
                phase_next = PHASE_SECOND;
                carry_next = new_carry;
            end
        endcase
        // The end of a message starts the next one from a clean group.
        if (s_final_byte) begin
            phase_next = PHASE_FIRST;
            carry_next = '0;
        end
    end

    // Group state advances only on an accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_FIRST;
            carry_reg <= '0;
        end else if (push) begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

@@ src/b64e_queue.sv @@
`timescale 1ns / 1ps

module b64e_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  b64e_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output b64e_pkg::job_t head_job
);
    import b64e_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    // Pointer wrap and fill count.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // The fill count never passes the depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    // Nothing is removed from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    // A lone push grows the count by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow queue count");

endmodule

@@ src/b64e_back.sv @@
`timescale 1ns / 1ps

module b64e_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  b64e_pkg::job_t head_job,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_char,
    output logic           m_end_of_text
);
    import b64e_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_out_char_reg;
    logic       m_end_of_text_reg;
    logic       load;
    logic       last_slot;

    assign m_valid       = m_valid_reg;
    assign m_out_char    = m_out_char_reg;
    assign m_end_of_text = m_end_of_text_reg;

    // The output register takes a new character when empty or being drained.
    assign load      = head_valid && (!m_valid_reg || m_ready);
    assign last_slot = ({1'b0, idx_reg} == (head_job.num_chars - 3'd1));
    assign pop       = load && last_slot;

    // Step through the head entry's characters, one per load.
    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            idx_next     = last_slot ? 2'd0 : idx_reg + 2'd1;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Character payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            m_out_char_reg    <= head_job.chars[idx_reg];
            m_end_of_text_reg <= head_job.msg_end && last_slot;
        end
    end

endmodule

@@ bench/base64_stream_encoder_tb.sv @@
`timescale 1ns / 1ps

module base64_stream_encoder_tb;

    import b64e_pkg::*;

    // Receiver pacing modes.
    localparam logic [1:0] READY_ALWAYS = 2'd0;
    localparam logic [1:0] READY_MOSTLY = 2'd1;
    localparam logic [1:0] READY_RARELY = 2'd2;

    // Long receiver hold-off, started once enough bytes have gone in.
    localparam int HOLDOFF_AFTER  = 40;
    localparam int HOLDOFF_CYCLES = 80;

    // Cycles allowed after the last character for stray output to show up.
    localparam int DRAIN_CYCLES = 20;

    // Standard alphabet, index 0 in the top byte.
    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } byte_req_t;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } char_exp_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_final_byte = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_char;
    logic       m_end_of_text;

    byte_req_t pending_bytes[$];
    char_exp_t expected_chars[$];

    // Predictor state: place in the three-byte group and the leftover bits.
    logic [1:0] enc_phase = PHASE_FIRST;
    logic [5:0] enc_carry = 6'd0;

    int        errors = 0;
    int        bytes_total = 0;
    int        bytes_accepted = 0;
    logic      s_taken = 1'b0;
    byte_req_t next_req;
    char_exp_t seen_char;
    char_exp_t want_char;

    // Sender burst and gap counters.
    int burst_left = 4;
    int gap_left = 0;

    // Receiver pacing state.
    logic [1:0] stall_mode = READY_ALWAYS;
    int         mode_left = 0;
    int         holdoff_left = 0;
    logic       holdoff_done = 1'b0;

    base64_stream_encoder uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_final_byte  (s_final_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_end_of_text (m_end_of_text)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] b64_symbol(input logic [5:0] idx);
        b64_symbol = B64_ALPHABET[8*(63 - idx) +: 8];
    endfunction

    function automatic char_exp_t plain_char(input logic [7:0] ch);
        char_exp_t c;
        c.ch = ch;
        c.eot = 1'b0;
        return c;
    endfunction

    // Works out the characters that one accepted byte produces.
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        char_exp_t tail;
        case (enc_phase)
            PHASE_SECOND: begin
                expected_chars.push_back(plain_char(b64_symbol(enc_carry | {2'b00, b[7:4]})));
                enc_carry = {b[3:0], 2'b00};
                enc_phase = PHASE_THIRD;
                if (fin) begin
                    expected_chars.push_back(plain_char(b64_symbol(enc_carry)));
                    expected_chars.push_back(plain_char(PAD_CHAR));
                end
            end
            PHASE_THIRD: begin
                expected_chars.push_back(plain_char(b64_symbol(enc_carry | {4'b0000, b[7:6]})));
                expected_chars.push_back(plain_char(b64_symbol(b[5:0])));
                enc_carry = 6'd0;
                enc_phase = PHASE_FIRST;
            end
            default: begin
                expected_chars.push_back(plain_char(b64_symbol(b[7:2])));
                enc_carry = {b[1:0], 4'b0000};
                enc_phase = PHASE_SECOND;
                if (fin) begin
                    expected_chars.push_back(plain_char(b64_symbol(enc_carry)));
                    expected_chars.push_back(plain_char(PAD_CHAR));
                    expected_chars.push_back(plain_char(PAD_CHAR));
                end
            end
        endcase
        // The final byte marks its last character and restarts the group.
        if (fin) begin
            tail = expected_chars.pop_back();
            tail.eot = 1'b1;
            expected_chars.push_back(tail);
            enc_phase = PHASE_FIRST;
            enc_carry = 6'd0;
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic fin);
        byte_req_t r;
        r.data = b;
        r.fin = fin;
        pending_bytes.push_back(r);
        bytes_total++;
    endtask

    // Sender: offers one request at a time, in bursts separated by gaps.
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_taken)) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                next_req = pending_bytes.pop_front();
                s_valid <= 1'b1;
                s_data_byte <= next_req.data;
                s_final_byte <= next_req.fin;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: switches between pacing modes, with one long hold-off.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            m_ready <= 1'b0;
        end else if (!holdoff_done && bytes_accepted >= HOLDOFF_AFTER) begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= 2'($urandom_range(0, 2));
                mode_left <= $urandom_range(8, 40);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                READY_ALWAYS: m_ready <= 1'b1;
                READY_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                READY_RARELY: m_ready <= ($urandom_range(0, 2) == 0);
                default:      m_ready <= 1'b1;
            endcase
        end
    end

    // Monitor: predicts on each input request and checks each output character.
    always @(posedge aclk) begin
        if (aresetn) begin
            s_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                encode_byte(s_data_byte, s_final_byte);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (m_valid && m_ready) begin
                seen_char.ch = m_out_char;
                seen_char.eot = m_end_of_text;
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected character 0x%02h end_of_text %0b",
                             $time, seen_char.ch, seen_char.eot);
                    errors++;
                end else begin
                    want_char = expected_chars.pop_front();
                    if (seen_char.ch !== want_char.ch) begin
                        $display("%0t: out_char expected 0x%02h actual 0x%02h",
                                 $time, want_char.ch, seen_char.ch);
                        errors++;
                    end
                    if (seen_char.eot !== want_char.eot) begin
                        $display("%0t: end_of_text expected %0b actual %0b",
                                 $time, want_char.eot, seen_char.eot);
                        errors++;
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int msg_len;
        int sent;

        // Single-byte messages at both extremes: two characters and two pads.
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        // Two-byte message hitting the plus and slash symbols, one pad.
        queue_byte(8'hFB, 1'b0);
        queue_byte(8'hFF, 1'b1);
        // Two full groups, no padding.
        queue_byte(8'h4D, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h6E, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        // A group followed by a lone byte in the next group.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h80, 1'b1);
        // Message ending on the second byte of its second group.
        queue_byte(8'h14, 1'b0);
        queue_byte(8'hFB, 1'b0);
        queue_byte(8'h9C, 1'b0);
        queue_byte(8'h03, 1'b0);
        queue_byte(8'hD8, 1'b1);
        // Alternating bit patterns.
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h55, 1'b1);

        // Random messages, mostly short, a few long ones.
        sent = 0;
        while (sent < 80) begin
            if ($urandom_range(0, 7) == 0) begin
                msg_len = $urandom_range(13, 30);
            end else begin
                msg_len = $urandom_range(1, 12);
            end
            for (int i = 0; i < msg_len; i++) begin
                queue_byte(8'($urandom_range(0, 255)), i == msg_len - 1);
            end
            sent += msg_len;
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (bytes_accepted != bytes_total || expected_chars.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_chars.size() != 0) begin
            $display("%0t: %0d characters never arrived", $time, expected_chars.size());
            errors++;
        end
        if (errors == 0) begin
            $display("PASS base64_stream_encoder");
        end else begin
            $display("FAIL base64_stream_encoder");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #1_000_000;
        $display("FAIL base64_stream_encoder");
        $finish;
    end

endmodule
